// ----- rtl/htcn_pkg.sv -----
// Shared constants, types and helper functions of the transition count normalizer.
`default_nettype none

package htcn_pkg;

  localparam int MaxStates = 8;
  localparam int Rows      = MaxStates + 1;
  localparam int InitRow   = MaxStates;
  localparam int Depth     = Rows * MaxStates;
  localparam int AddrW     = $clog2(Depth);
  localparam int StateW    = 3;
  localparam int RowW      = 4;
  localparam int ActW      = 4;
  localparam int CntW      = 24;
  localparam int SumW      = CntW + $clog2(MaxStates);
  localparam int ProbW     = 17;

  localparam logic [CntW-1:0]  CountMax = {CntW{1'b1}};
  localparam logic [ProbW-1:0] QOne     = ProbW'(65536);

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_SYMBOL = 2'd1,
    REQ_NORM   = 2'd2,
    REQ_READ   = 2'd3
  } req_type_e;

  localparam logic ReplyNorm = 1'b0;
  localparam logic ReplyRead = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

  // Flat store address of one entry: row-major, MaxStates entries per row.
  function automatic logic [AddrW-1:0] cell_addr(input logic [RowW-1:0]   row,
                                                 input logic [StateW-1:0] col);
    cell_addr = AddrW'(int'(row) * MaxStates + int'(col));
  endfunction

  // Uniform probability floor(65536 / n) for a row whose count sum is zero.
  function automatic logic [ProbW-1:0] uniform_prob(input logic [ActW-1:0] n);
    logic [ProbW-1:0] p;
    p = ProbW'(8192);
    unique case (n)
      4'd1:    p = QOne;
      4'd2:    p = ProbW'(32768);
      4'd3:    p = ProbW'(21845);
      4'd4:    p = ProbW'(16384);
      4'd5:    p = ProbW'(13107);
      4'd6:    p = ProbW'(10922);
      4'd7:    p = ProbW'(9362);
      default: p = ProbW'(8192);
    endcase
    uniform_prob = p;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/htcn_ram.sv -----
// Synchronous single-write, single-read memory whose entries read as zero until written.
`default_nettype none

module htcn_ram #(
  parameter int Width = 24,
  parameter int Depth = 72
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       clr_i,
  input  wire                       we_i,
  input  wire [$clog2(Depth)-1:0]   waddr_i,
  input  wire [Width-1:0]           wdata_i,
  input  wire                       re_i,
  input  wire [$clog2(Depth)-1:0]   raddr_i,
  output logic [Width-1:0]          rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Depth-1:0] vld_q;
  logic [Width-1:0] rdata_q;
  logic             rvld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  // Per-entry valid bits give the zero reset value and the whole-store clear.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (clr_i) begin
        vld_q <= '0;
      end else if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvld_q <= vld_q[raddr_i];
      end
    end
  end

  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

`default_nettype wire

// ----- rtl/htcn_divider.sv -----
// Bit-serial restoring divider giving floor(num * 65536 / den) for num <= den.
`default_nettype none

module htcn_divider (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         start_i,
  input  wire [htcn_pkg::CntW-1:0]    num_i,
  input  wire [htcn_pkg::SumW-1:0]    den_i,
  output logic [htcn_pkg::ProbW-1:0]  quot_o,
  output htcn_pkg::div_sts_t          sts_o
);

  import htcn_pkg::*;

  localparam int RemW = SumW + 1;
  localparam int CntBitsW = $clog2(ProbW + 1);

  logic [RemW-1:0]     rem_q;
  logic [SumW-1:0]     den_q;
  logic [ProbW-1:0]    quot_q;
  logic [CntBitsW-1:0] step_q;
  logic                busy_q;
  logic                done_q;

  logic            ge;
  logic [RemW-1:0] diff;

  // One quotient bit per cycle, most significant first.
  assign ge   = rem_q >= {1'b0, den_q};
  assign diff = ge ? rem_q - {1'b0, den_q} : rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= CntBitsW'(ProbW);
      end else if (busy_q) begin
        step_q <= step_q - 1'b1;
        if (step_q == CntBitsW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= RemW'(num_i);
      den_q  <= den_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= {diff[RemW-2:0], 1'b0};
      quot_q <= {quot_q[ProbW-2:0], ge};
    end
  end

  assign quot_o     = quot_q;
  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;

endmodule

`default_nettype wire

// ----- rtl/hmm_transition_count_normalize_top.sv -----
// Top level of the transition count normalizer: request sequencer, stores and reply register.
`default_nettype none

// Channel   Direction  Handshake               Payload
// in        input      in_valid_i/in_ready_o   req_type, decoded_state, seq_start, read_row,
//                                              read_col
// out       output     out_valid_o/out_ready_i prob_value, committed, reply_kind
// cfg       input      cfg_we_i (no wait)      cfg_wdata_i -> active_states
//
// A clear beat, like an ignored symbol, leaves the sequencer idle. A counted symbol reads its
// count, then writes back the count plus one unless it is saturated; a read beat reads the
// store, then waits out any stall on the reply register.
// A normalize with no counted sequence goes straight to the reply. A committed normalize sweeps
// all 72 probability entries: each row first sums its N counts, then each active entry is set by
// the 17-step bit-serial divider, or uniformly if the sum is zero, and each inactive one to zero.
// Reset zeroes both stores at once through per-entry valid bits; no clearing pass is needed.
// The input side stays ready while a finished reply waits in the output register; only the
// step that produces a new reply waits for that register to empty.

module hmm_transition_count_normalize_top (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  wire [1:0]                    req_type_i,
  input  wire [htcn_pkg::StateW-1:0]   decoded_state_i,
  input  wire                          seq_start_i,
  input  wire [htcn_pkg::RowW-1:0]     read_row_i,
  input  wire [htcn_pkg::StateW-1:0]   read_col_i,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output logic [htcn_pkg::ProbW-1:0]   prob_value_o,
  output logic                         committed_o,
  output logic                         reply_kind_o,
  input  wire                          cfg_we_i,
  input  wire [htcn_pkg::ActW-1:0]     cfg_wdata_i
);

  import htcn_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SYM_WR,
    S_RD_DATA,
    S_SUM_RD,
    S_SUM_ACC,
    S_COL_RD,
    S_COL_DAT,
    S_COL_DIV,
    S_REPLY
  } state_e;

  state_e            state_q;
  logic [ActW-1:0]   act_q;
  logic [StateW-1:0] prev_q;
  logic              seen_q;
  logic [AddrW-1:0]  addr_q;
  logic              rd_oor_q;
  logic              commit_q;
  logic [RowW-1:0]   row_q;
  logic [StateW-1:0] col_q;
  logic [SumW-1:0]   sum_q;

  logic              out_valid_q;
  logic [ProbW-1:0]  out_prob_q;
  logic              out_commit_q;
  logic              out_kind_q;

  req_type_e         req;
  logic              accept;
  logic              out_free;
  logic              reply_load;
  logic [ActW-1:0]   n_eff;
  logic              sym_ok;
  logic [RowW-1:0]   sym_row;
  logic              entry_act;
  logic [AddrW-1:0]  cur_addr;

  logic              cnt_re;
  logic [AddrW-1:0]  cnt_raddr;
  logic              cnt_we;
  logic              cnt_clr;
  logic [CntW-1:0]   cnt_rdata;

  logic              prob_re;
  logic [AddrW-1:0]  prob_raddr;
  logic              prob_we;
  logic [ProbW-1:0]  prob_wdata;
  logic [ProbW-1:0]  prob_rdata;

  logic              div_start;
  logic [ProbW-1:0]  div_quot;
  div_sts_t          div_sts;

  logic              last_col;
  logic              last_row;
  logic              sum_last;
  logic              advance;

  assign req        = req_type_e'(req_type_i);
  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // A new reply enters the output register once it is free.
  assign reply_load = ((state_q == S_RD_DATA) || (state_q == S_REPLY)) && out_free;

  // Out-of-range register values are clamped into 1..MaxStates.
  always_comb begin
    if (act_q == '0) begin
      n_eff = ActW'(1);
    end else if (act_q > ActW'(MaxStates)) begin
      n_eff = ActW'(MaxStates);
    end else begin
      n_eff = act_q;
    end
  end

  // A symbol counts only if it lies among the active states and, unless it starts a
  // sequence, follows a counted start.
  assign sym_ok  = ({1'b0, decoded_state_i} < n_eff) && (seq_start_i || seen_q);
  assign sym_row = seq_start_i ? RowW'(InitRow) : RowW'(prev_q);

  assign entry_act = ((row_q == RowW'(InitRow)) || (row_q < n_eff)) &&
                     ({1'b0, col_q} < n_eff);
  assign cur_addr  = cell_addr(row_q, col_q);

  assign last_col = (col_q == StateW'(MaxStates - 1));
  assign last_row = (row_q == RowW'(InitRow));
  assign sum_last = ({1'b0, col_q} == n_eff - 1'b1);

  // The sweep moves to the next entry once the current one has been written.
  assign advance = (state_q == S_COL_RD && !entry_act) ||
                   (state_q == S_COL_DAT && sum_q == '0) ||
                   (state_q == S_COL_DIV && div_sts.done);

  // Count store: symbol read-modify-write and the normalize sweep.
  assign cnt_clr   = accept && (req == REQ_CLEAR);
  assign cnt_re    = (accept && req == REQ_SYMBOL) || (state_q == S_SUM_RD) ||
                     (state_q == S_COL_RD && entry_act);
  assign cnt_raddr = (state_q == S_IDLE) ? cell_addr(sym_row, decoded_state_i) : cur_addr;
  assign cnt_we    = (state_q == S_SYM_WR) && (cnt_rdata != CountMax);

  htcn_ram #(
    .Width (CntW),
    .Depth (Depth)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clr_i   (cnt_clr),
    .we_i    (cnt_we),
    .waddr_i (addr_q),
    .wdata_i (cnt_rdata + 1'b1),
    .re_i    (cnt_re),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rdata)
  );

  // Probability store: read requests and the normalize write sweep.
  assign prob_re    = accept && (req == REQ_READ) && (read_row_i <= RowW'(InitRow));
  assign prob_raddr = cell_addr(read_row_i, read_col_i);
  assign prob_we    = advance;

  always_comb begin
    case (state_q)
      S_COL_DAT: prob_wdata = uniform_prob(n_eff);
      S_COL_DIV: prob_wdata = div_quot;
      default:   prob_wdata = '0;
    endcase
  end

  htcn_ram #(
    .Width (ProbW),
    .Depth (Depth)
  ) u_prob_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clr_i   (1'b0),
    .we_i    (prob_we),
    .waddr_i (cur_addr),
    .wdata_i (prob_wdata),
    .re_i    (prob_re),
    .raddr_i (prob_raddr),
    .rdata_o (prob_rdata)
  );

  assign div_start = (state_q == S_COL_DAT) && (sum_q != '0);

  htcn_divider u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (cnt_rdata),
    .den_i   (sum_q),
    .quot_o  (div_quot),
    .sts_o   (div_sts)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      act_q        <= ActW'(MaxStates);
      prev_q       <= '0;
      seen_q       <= 1'b0;
      addr_q       <= '0;
      rd_oor_q     <= 1'b0;
      commit_q     <= 1'b0;
      row_q        <= '0;
      col_q        <= '0;
      sum_q        <= '0;
      out_valid_q  <= 1'b0;
      out_prob_q   <= '0;
      out_commit_q <= 1'b0;
      out_kind_q   <= ReplyNorm;
    end else begin
      if (cfg_we_i) begin
        act_q <= cfg_wdata_i;
      end
      if (reply_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            unique case (req)
              REQ_CLEAR: begin
                prev_q <= '0;
                seen_q <= 1'b0;
              end
              REQ_SYMBOL: begin
                if (sym_ok) begin
                  prev_q  <= decoded_state_i;
                  addr_q  <= cnt_raddr;
                  state_q <= S_SYM_WR;
                  if (seq_start_i) begin
                    seen_q <= 1'b1;
                  end
                end
              end
              REQ_NORM: begin
                commit_q <= seen_q;
                row_q    <= '0;
                col_q    <= '0;
                sum_q    <= '0;
                state_q  <= seen_q ? S_SUM_RD : S_REPLY;
              end
              REQ_READ: begin
                rd_oor_q <= (read_row_i > RowW'(InitRow));
                state_q  <= S_RD_DATA;
              end
              default: ;
            endcase
          end
        end
        S_SYM_WR: begin
          state_q <= S_IDLE;
        end
        S_RD_DATA: begin
          if (out_free) begin
            out_prob_q   <= rd_oor_q ? '0 : prob_rdata;
            out_commit_q <= 1'b0;
            out_kind_q   <= ReplyRead;
            state_q      <= S_IDLE;
          end
        end
        S_SUM_RD: begin
          state_q <= S_SUM_ACC;
        end
        S_SUM_ACC: begin
          sum_q <= sum_q + SumW'(cnt_rdata);
          if (sum_last) begin
            col_q   <= '0;
            state_q <= S_COL_RD;
          end else begin
            col_q   <= col_q + 1'b1;
            state_q <= S_SUM_RD;
          end
        end
        S_COL_RD: begin
          if (entry_act) begin
            state_q <= S_COL_DAT;
          end
        end
        S_COL_DAT: begin
          if (sum_q != '0) begin
            state_q <= S_COL_DIV;
          end
        end
        S_COL_DIV: ;
        S_REPLY: begin
          if (out_free) begin
            out_prob_q   <= '0;
            out_commit_q <= commit_q;
            out_kind_q   <= ReplyNorm;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase

      // Step to the next entry of the sweep; a finished row restarts the sum pass, the last row ends in the reply.
      if (advance) begin
        if (last_col) begin
          col_q <= '0;
          if (last_row) begin
            state_q <= S_REPLY;
          end else begin
            row_q   <= row_q + 1'b1;
            sum_q   <= '0;
            state_q <= S_SUM_RD;
          end
        end else begin
          col_q   <= col_q + 1'b1;
          state_q <= S_COL_RD;
        end
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign prob_value_o = out_prob_q;
  assign committed_o  = out_commit_q;
  assign reply_kind_o = out_kind_q;

`ifndef ASSERT_OFF
  // The divider only finishes while the sweep waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_sts.done |-> state_q == S_COL_DIV)
    else $error("divider finished outside the divide wait");

  // While the sweep waits for a quotient, the divider is running or just done.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_COL_DIV |-> (div_sts.busy || div_sts.done))
    else $error("sweep waits on an idle divider");

  // A normalize reply never carries a probability.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && reply_kind_o == ReplyNorm) |-> prob_value_o == '0)
    else $error("normalize reply with nonzero probability");

  // A read reply never claims a commit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && reply_kind_o == ReplyRead) |-> !committed_o)
    else $error("read reply marked committed");

  // Probabilities change only during the normalize sweep.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    prob_we |-> (state_q == S_COL_RD || state_q == S_COL_DAT || state_q == S_COL_DIV))
    else $error("probability write outside normalize");
`endif

endmodule

`default_nettype wire
